/* rtl/core/fspa_pkg.sv */
// ============================================================================
// fspa_pkg
// Shared types and constants of the fixed-slot pool allocator: operation and
// status codes, field widths, and the command and status bundles passed
// between the controller and the datapath.
// ============================================================================
package fspa_pkg;

    // Fixed field widths of the request and response beats.
    localparam int OP_W     = 2;
    localparam int HANDLE_W = 10;
    localparam int STATUS_W = 2;

    // Default pool geometry.
    localparam int DEF_SLOTS      = 64;
    localparam int DEF_MAX_BLOCKS = 16;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC    = 2'd0,
        OP_FREE     = 2'd1,
        OP_FREE_ALL = 2'd2,
        OP_QUERY    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOT_USED = 2'd3
    } status_t;

    // Datapath micro-operations issued by the controller.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_DECODE,
        CMD_LOOKUP,
        CMD_UNLINK_NEXT,
        CMD_UNLINK_PREV,
        CMD_PUSH,
        CMD_DEC,
        CMD_OPEN,
        CMD_WRAP_INIT,
        CMD_TAKE_RD,
        CMD_TAKE_WR,
        CMD_FA_INIT,
        CMD_FA_READ,
        CMD_FA_PUSH,
        CMD_FA_NEXT
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        logic    load_out;
        status_t out_status;
        logic    out_grant;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic open_zero;
        logic open_full;
        logic has_free;
        logic wb_zero;
        logic wb_above_cur;
        logic out_of_range;
        logic slot_busy;
        logic slot_valid;
        logic out_free;
    } dp_stat_t;

endpackage

/* rtl/core/fspa_req_if.sv */
// ============================================================================
// fspa_req_if
// Request channel: operation and handle with a valid/ready handshake.
// ============================================================================
interface fspa_req_if import fspa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [HANDLE_W-1:0] handle;

    modport source (output valid, output operation, output handle, input ready);
    modport sink   (input valid, input operation, input handle, output ready);
endinterface

/* rtl/core/fspa_rsp_if.sv */
// ============================================================================
// fspa_rsp_if
// Response channel: status and granted handle with a valid/ready handshake.
// ============================================================================
interface fspa_rsp_if import fspa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] granted_handle;

    modport source (output valid, output status, output granted_handle, input ready);
    modport sink   (input valid, input status, input granted_handle, output ready);
endinterface

/* rtl/core/fspa_ctrl.sv */
// ============================================================================
// fspa_ctrl
// Controller of the pool allocator. Sequences the datapath through the
// allocate search, free, query and free-all walks, one request at a time.
// ============================================================================
module fspa_ctrl import fspa_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_OPEN,
        S_WRAP_INIT,
        S_WRAP,
        S_TAKE_RD,
        S_TAKE_WR,
        S_DECODE,
        S_LOOKUP,
        S_CHECK,
        S_UNLINK_PREV,
        S_PUSH,
        S_FA_INIT,
        S_FA_CHECK,
        S_FA_PUSH,
        S_FINISH
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    status_t fin_status_reg;
    status_t fin_status_next;
    logic    fin_grant_reg;
    logic    fin_grant_next;

    // Next state and the command issued in the present cycle.
    always_comb
    begin
        state_next      = state_reg;
        fin_status_next = fin_status_reg;
        fin_grant_next  = fin_grant_reg;
        cmd.op          = CMD_NONE;
        cmd.load_out    = 1'b0;
        cmd.out_status  = fin_status_reg;
        cmd.out_grant   = fin_grant_reg;
        in_ready        = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = CMD_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.op)
                    OP_ALLOC:    state_next = S_SCAN;
                    OP_FREE_ALL: state_next = S_FA_INIT;
                    OP_FREE:     state_next = S_DECODE;
                    OP_QUERY:    state_next = S_DECODE;
                endcase
            end
            S_SCAN:
            begin
                priority if (stat.open_zero)
                    state_next = S_OPEN;
                else if (stat.has_free)
                    state_next = S_TAKE_RD;
                else if (!stat.wb_zero)
                    cmd.op = CMD_DEC;
                else if (stat.open_full)
                    state_next = S_WRAP_INIT;
                else
                    state_next = S_OPEN;
            end
            S_OPEN:
            begin
                cmd.op     = CMD_OPEN;
                state_next = S_TAKE_RD;
            end
            S_WRAP_INIT:
            begin
                cmd.op     = CMD_WRAP_INIT;
                state_next = S_WRAP;
            end
            S_WRAP:
            begin
                priority if (!stat.wb_above_cur)
                begin
                    fin_status_next = ST_FULL;
                    fin_grant_next  = 1'b0;
                    state_next      = S_FINISH;
                end
                else if (stat.has_free)
                    state_next = S_TAKE_RD;
                else
                    cmd.op = CMD_DEC;
            end
            S_TAKE_RD:
            begin
                cmd.op     = CMD_TAKE_RD;
                state_next = S_TAKE_WR;
            end
            S_TAKE_WR:
            begin
                cmd.op          = CMD_TAKE_WR;
                fin_status_next = ST_OK;
                fin_grant_next  = 1'b1;
                state_next      = S_FINISH;
            end
            S_DECODE:
            begin
                cmd.op     = CMD_DECODE;
                state_next = S_LOOKUP;
            end
            S_LOOKUP:
            begin
                if (stat.out_of_range)
                begin
                    fin_status_next = ST_RANGE;
                    fin_grant_next  = 1'b0;
                    state_next      = S_FINISH;
                end
                else
                begin
                    cmd.op     = CMD_LOOKUP;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                fin_grant_next = 1'b0;
                priority if (!stat.slot_busy)
                begin
                    fin_status_next = ST_NOT_USED;
                    state_next      = S_FINISH;
                end
                else if (stat.op == OP_QUERY)
                begin
                    fin_status_next = ST_OK;
                    state_next      = S_FINISH;
                end
                else
                begin
                    cmd.op     = CMD_UNLINK_NEXT;
                    state_next = S_UNLINK_PREV;
                end
            end
            S_UNLINK_PREV:
            begin
                cmd.op     = CMD_UNLINK_PREV;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                cmd.op          = CMD_PUSH;
                fin_status_next = ST_OK;
                fin_grant_next  = 1'b0;
                state_next      = S_FINISH;
            end
            S_FA_INIT:
            begin
                fin_status_next = ST_OK;
                fin_grant_next  = 1'b0;
                if (stat.open_zero)
                    state_next = S_FINISH;
                else
                begin
                    cmd.op     = CMD_FA_INIT;
                    state_next = S_FA_CHECK;
                end
            end
            S_FA_CHECK:
            begin
                if (stat.slot_valid)
                begin
                    cmd.op     = CMD_FA_READ;
                    state_next = S_FA_PUSH;
                end
                else
                begin
                    cmd.op = CMD_FA_NEXT;
                    if (stat.wb_zero)
                        state_next = S_FINISH;
                end
            end
            S_FA_PUSH:
            begin
                cmd.op     = CMD_FA_PUSH;
                state_next = S_FA_CHECK;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
        endcase
    end

    // State and the registered result code.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fin_status_reg <= ST_OK;
            fin_grant_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fin_status_reg <= fin_status_next;
            fin_grant_reg  <= fin_grant_next;
        end
    end

endmodule

/* rtl/core/fspa_dpath.sv */
// ============================================================================
// fspa_dpath
// Datapath of the pool allocator: per-slot link memories, per-block list
// heads and fill marks, the handle decoder and the response register.
// ============================================================================
module fspa_dpath import fspa_pkg::*; #(
    parameter int SLOTS      = DEF_SLOTS,
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  logic [OP_W-1:0]     in_operation,
    input  logic [HANDLE_W-1:0] in_handle,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [STATUS_W-1:0] out_status,
    output logic [HANDLE_W-1:0] out_granted_handle
);

    localparam int DEPTH   = MAX_BLOCKS * SLOTS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int LINK_W  = $clog2(SLOTS + 1);
    localparam int BLK_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int OPEN_W  = $clog2(MAX_BLOCKS + 1);
    localparam int RSHIFT  = 2 * HANDLE_W + 1;
    localparam int RECIP   = ((2 ** RSHIFT) + SLOTS - 1) / SLOTS;
    localparam int QPROD_W = HANDLE_W + RSHIFT;
    localparam int REM_W   = HANDLE_W + LINK_W;
    localparam int AMUL_W  = BLK_W + ADDR_W;
    localparam int GW_W    = HANDLE_W + ADDR_W;
    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(SLOTS);

    // Per-slot memories; their contents are only used once written.
    logic [LINK_W-1:0] fnext_mem [DEPTH];
    logic [LINK_W-1:0] unext_mem [DEPTH];
    logic [LINK_W-1:0] uprev_mem [DEPTH];
    logic              busy_mem  [DEPTH];

    // Per-block list heads and fill marks; set when the block is opened.
    logic [LINK_W-1:0] free_head_reg [MAX_BLOCKS];
    logic [LINK_W-1:0] used_head_reg [MAX_BLOCKS];
    logic [LINK_W-1:0] fresh_reg     [MAX_BLOCKS];

    logic [OPEN_W-1:0]   open_reg;
    logic [BLK_W-1:0]    cur_reg;
    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [HANDLE_W-1:0] out_handle_reg;

    logic [OP_W-1:0]     op_reg;
    logic [HANDLE_W-1:0] h_reg;
    logic [HANDLE_W-1:0] q_reg;
    logic                oor_reg;
    logic [BLK_W-1:0]    wb_reg;
    logic [LINK_W-1:0]   ws_reg;
    logic [LINK_W-1:0]   nx_reg;
    logic [LINK_W-1:0]   pv_reg;
    logic [LINK_W-1:0]   old_reg;
    logic [HANDLE_W-1:0] grant_reg;

    logic [LINK_W-1:0] rd_fnext;
    logic [LINK_W-1:0] rd_unext;
    logic [LINK_W-1:0] rd_uprev;
    logic              rd_busy;

    logic [LINK_W-1:0]  fh_cur;
    logic [LINK_W-1:0]  uh_cur;
    logic [LINK_W-1:0]  fr_cur;
    logic [ADDR_W-1:0]  mem_addr;
    logic [QPROD_W-1:0] q_prod;
    logic [REM_W-1:0]   rem_wide;
    logic [OPEN_W-1:0]  open_last;
    logic [BLK_W-1:0]   last_blk;
    logic [BLK_W-1:0]   new_blk;
    logic [BLK_W-1:0]   wb_dec;
    logic               virgin;
    logic [HANDLE_W-1:0] take_handle;

    logic              fnext_we;
    logic              unext_we;
    logic              uprev_we;
    logic              busy_we;
    logic [LINK_W-1:0] unext_wd;
    logic [LINK_W-1:0] uprev_wd;

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [BLK_W-1:0]  b,
                                                    input logic [SLOT_W-1:0] s);
        logic [AMUL_W-1:0] prod;
        prod = AMUL_W'(b) * AMUL_W'(SLOTS);
        return prod[ADDR_W-1:0] + ADDR_W'(s);
    endfunction

    function automatic logic [HANDLE_W-1:0] to_handle(input logic [ADDR_W-1:0] a);
        logic [GW_W-1:0] wide;
        wide = GW_W'(a);
        return wide[HANDLE_W-1:0];
    endfunction

    // Block-level views of the working block.
    assign fh_cur    = free_head_reg[wb_reg];
    assign uh_cur    = used_head_reg[wb_reg];
    assign fr_cur    = fresh_reg[wb_reg];
    assign open_last = open_reg - OPEN_W'(1);
    assign last_blk  = open_last[BLK_W-1:0];
    assign new_blk   = open_reg[BLK_W-1:0];
    assign wb_dec    = wb_reg - BLK_W'(1);
    assign virgin    = (ws_reg == fr_cur);
    assign take_handle = to_handle(slot_addr(wb_reg, ws_reg[SLOT_W-1:0]));

    // Handle decode: quotient by reciprocal, then remainder.
    assign q_prod   = QPROD_W'(in_handle) * QPROD_W'(RECIP);
    assign rem_wide = REM_W'(h_reg) - (REM_W'(q_reg) * REM_W'(SLOTS));

    // Shared slot address for the per-slot memories.
    always_comb
    begin
        unique case (cmd.op)
            CMD_TAKE_RD:     mem_addr = slot_addr(wb_reg, fh_cur[SLOT_W-1:0]);
            CMD_TAKE_WR:     mem_addr = slot_addr(wb_reg, old_reg[SLOT_W-1:0]);
            CMD_UNLINK_NEXT: mem_addr = slot_addr(wb_reg, rd_unext[SLOT_W-1:0]);
            CMD_UNLINK_PREV: mem_addr = slot_addr(wb_reg, pv_reg[SLOT_W-1:0]);
            default:         mem_addr = slot_addr(wb_reg, ws_reg[SLOT_W-1:0]);
        endcase
    end

    // Write strobes and data of the per-slot memories.
    always_comb
    begin
        busy_we  = (cmd.op == CMD_TAKE_RD) || (cmd.op == CMD_PUSH)
                || (cmd.op == CMD_FA_PUSH);
        fnext_we = (cmd.op == CMD_PUSH) || (cmd.op == CMD_FA_PUSH);
        unext_we = (cmd.op == CMD_TAKE_RD)
                || ((cmd.op == CMD_UNLINK_PREV) && (pv_reg < LINK_NONE));
        unext_wd = (cmd.op == CMD_TAKE_RD) ? uh_cur : nx_reg;
        uprev_we = (cmd.op == CMD_TAKE_RD)
                || ((cmd.op == CMD_TAKE_WR) && (old_reg < LINK_NONE))
                || ((cmd.op == CMD_UNLINK_NEXT) && (rd_unext < LINK_NONE));
        if (cmd.op == CMD_TAKE_RD)
            uprev_wd = LINK_NONE;
        else if (cmd.op == CMD_TAKE_WR)
            uprev_wd = ws_reg;
        else
            uprev_wd = rd_uprev;
    end

    // Per-slot memories with registered read data.
    always_ff @(posedge clk)
    begin
        if (fnext_we)
            fnext_mem[mem_addr] <= fh_cur;
        if (cmd.op == CMD_TAKE_RD)
            rd_fnext <= fnext_mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (unext_we)
            unext_mem[mem_addr] <= unext_wd;
        if ((cmd.op == CMD_LOOKUP) || (cmd.op == CMD_FA_READ))
            rd_unext <= unext_mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (uprev_we)
            uprev_mem[mem_addr] <= uprev_wd;
        if (cmd.op == CMD_LOOKUP)
            rd_uprev <= uprev_mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (busy_we)
            busy_mem[mem_addr] <= (cmd.op == CMD_TAKE_RD);
        if (cmd.op == CMD_LOOKUP)
            rd_busy <= busy_mem[mem_addr];
    end

    // Control state: open block count, current block, response valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg      <= '0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == CMD_OPEN)
                open_reg <= open_reg + OPEN_W'(1);
            if (cmd.op == CMD_TAKE_RD)
                cur_reg <= wb_reg;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers and per-block heads.
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            CMD_LOAD:
            begin
                op_reg <= in_operation;
                h_reg  <= in_handle;
                q_reg  <= q_prod[RSHIFT +: HANDLE_W];
                wb_reg <= cur_reg;
            end
            CMD_DECODE:
            begin
                wb_reg  <= q_reg[BLK_W-1:0];
                ws_reg  <= rem_wide[LINK_W-1:0];
                oor_reg <= (q_reg >= HANDLE_W'(open_reg));
            end
            CMD_UNLINK_NEXT:
            begin
                nx_reg <= rd_unext;
                pv_reg <= rd_uprev;
            end
            CMD_UNLINK_PREV:
            begin
                if (pv_reg >= LINK_NONE)
                    used_head_reg[wb_reg] <= nx_reg;
            end
            CMD_PUSH:
                free_head_reg[wb_reg] <= ws_reg;
            CMD_DEC:
                wb_reg <= wb_dec;
            CMD_OPEN:
            begin
                wb_reg                 <= new_blk;
                fresh_reg[new_blk]     <= '0;
                free_head_reg[new_blk] <= '0;
                used_head_reg[new_blk] <= LINK_NONE;
            end
            CMD_WRAP_INIT:
                wb_reg <= BLK_W'(MAX_BLOCKS - 1);
            CMD_TAKE_RD:
            begin
                ws_reg  <= fh_cur;
                old_reg <= uh_cur;
            end
            CMD_TAKE_WR:
            begin
                if (virgin)
                begin
                    free_head_reg[wb_reg] <= ws_reg + LINK_W'(1);
                    fresh_reg[wb_reg]     <= fr_cur + LINK_W'(1);
                end
                else
                    free_head_reg[wb_reg] <= rd_fnext;
                used_head_reg[wb_reg] <= ws_reg;
                grant_reg             <= take_handle;
            end
            CMD_FA_INIT:
            begin
                wb_reg <= last_blk;
                ws_reg <= used_head_reg[last_blk];
            end
            CMD_FA_PUSH:
            begin
                free_head_reg[wb_reg] <= ws_reg;
                ws_reg                <= rd_unext;
            end
            CMD_FA_NEXT:
            begin
                used_head_reg[wb_reg] <= LINK_NONE;
                if (wb_reg != '0)
                begin
                    wb_reg <= wb_dec;
                    ws_reg <= used_head_reg[wb_dec];
                end
            end
            default:
            begin
            end
        endcase
    end

    // Response payload register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status_reg <= cmd.out_status;
            out_handle_reg <= cmd.out_grant ? grant_reg : '0;
        end
    end

    // Status back to the controller.
    always_comb
    begin
        stat.op           = op_t'(op_reg);
        stat.open_zero    = (open_reg == '0);
        stat.open_full    = (open_reg == OPEN_W'(MAX_BLOCKS));
        stat.has_free     = (fh_cur < LINK_NONE);
        stat.wb_zero      = (wb_reg == '0);
        stat.wb_above_cur = (wb_reg > cur_reg);
        stat.out_of_range = oor_reg;
        stat.slot_busy    = rd_busy && (ws_reg < fr_cur);
        stat.slot_valid   = (ws_reg < LINK_NONE);
        stat.out_free     = !out_valid_reg || out_ready;
    end

    assign out_valid          = out_valid_reg;
    assign out_status         = out_status_reg;
    assign out_granted_handle = out_handle_reg;

endmodule

/* rtl/core/fixed_slot_pool_allocator.sv */
// ============================================================================
// fixed_slot_pool_allocator
// Slot allocator over lazily opened blocks, each with a LIFO free list and a
// doubly linked in-use list. Allocates, frees by handle, frees all and
// answers in-use queries.
//
//   Channel | Role | Beat payload
//   --------+------+------------------------------------
//   req     | sink | operation, handle
//   rsp     | src  | status, granted_handle
//
// One request is worked at a time through the single-port slot memories.
// Allocate searches the current block and those below it, opens a new block
// when none has a free slot and blocks remain, and else wraps the search to
// the upper blocks. Free all walks every in-use slot of each open block.
// Reset clears the open block count, current block and response valid; blocks
// are set up as they open, so no clearing pass is needed. A stalled response
// is held in its register and the next request is accepted meanwhile.
// ============================================================================
module fixed_slot_pool_allocator import fspa_pkg::*; #(
    parameter int SLOTS      = DEF_SLOTS,
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  logic       clk,
    input  logic       rst_n,
    fspa_req_if.sink   req,
    fspa_rsp_if.source rsp
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer.
    fspa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Storage and arithmetic.
    fspa_dpath #(
        .SLOTS      (SLOTS),
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dpath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .in_operation       (req.operation),
        .in_handle          (req.handle),
        .out_ready          (rsp.ready),
        .out_valid          (rsp.valid),
        .out_status         (rsp.status),
        .out_granted_handle (rsp.granted_handle)
    );

endmodule

/* rtl/core/fspa_checker.sv */
// ============================================================================
// fspa_checker
// Port-level checks of the pool allocator, bound to the top level.
// ============================================================================
module fspa_checker import fspa_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] rsp_status,
    input logic [HANDLE_W-1:0] rsp_granted_handle
);

    // Only a successful allocate carries a handle.
    a_handle_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_OK) |-> rsp_granted_handle == '0)
        else $error("handle returned with a failing status");

    // A stalled response beat holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                   && $stable(rsp_granted_handle))
        else $error("stalled response changed");

    // A request in work blocks the next one in the following cycle.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in work");

endmodule

bind fixed_slot_pool_allocator fspa_checker u_fspa_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_status         (rsp.status),
    .rsp_granted_handle (rsp.granted_handle)
);

/* sim/tb_fixed_slot_pool_allocator.sv */
// ============================================================================
// Fixed-slot pool allocator testbench
// Drives allocate, free, free-all and query requests under several idling
// phases, predicts each response with a behavioural model of the block and
// checks every response beat against it in order.
// ============================================================================
module tb_fixed_slot_pool_allocator;
    import fspa_pkg::*;

    localparam int SLOTS      = DEF_SLOTS;
    localparam int MAX_BLOCKS = DEF_MAX_BLOCKS;
    localparam int TOTAL      = SLOTS * MAX_BLOCKS;
    localparam int NONE       = SLOTS;
    localparam int CYCLE_LIMIT = 900000;

    typedef struct packed {
        status_t             status;
        logic [HANDLE_W-1:0] granted;
    } answer_t;

    int   cycle_count;

    // Behavioural model of the pool with its expected response queue.
    class pool_scoreboard;
        int      free_next [TOTAL];
        int      used_next [TOTAL];
        int      used_prev [TOTAL];
        bit      busy [TOTAL];
        int      free_head [MAX_BLOCKS];
        int      used_head [MAX_BLOCKS];
        int      open_cnt;
        int      cur_blk;
        answer_t pending [$];
        int      errors;

        function void clear();
            foreach (busy[i]) busy[i] = 0;
            open_cnt = 0;
            cur_blk  = 0;
            pending.delete();
            errors = 0;
        endfunction

        // Print one mismatch line and count it.
        function void report_mismatch(string msg);
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
            errors++;
        endfunction

        function int take_slot(int b);
            int s;
            int base;
            int old;
            s    = free_head[b];
            base = b * SLOTS;
            old  = used_head[b];
            free_head[b] = free_next[base + s];
            busy[base + s] = 1;
            used_prev[base + s] = NONE;
            used_next[base + s] = old;
            if (old < SLOTS)
                used_prev[base + old] = s;
            used_head[b] = s;
            return base + s;
        endfunction

        function bit allocate(output int h);
            int b;
            if (open_cnt > 0)
            begin
                for (b = cur_blk; b >= 0; b--)
                begin
                    if (free_head[b] < SLOTS)
                    begin
                        cur_blk = b;
                        h = take_slot(b);
                        return 1;
                    end
                end
            end
            if (open_cnt < MAX_BLOCKS)
            begin
                b = open_cnt;
                for (int s = 0; s < SLOTS; s++)
                begin
                    free_next[b * SLOTS + s] = s + 1;
                    used_next[b * SLOTS + s] = NONE;
                    used_prev[b * SLOTS + s] = NONE;
                    busy[b * SLOTS + s] = 0;
                end
                free_head[b] = 0;
                used_head[b] = NONE;
                open_cnt = b + 1;
                cur_blk  = b;
                h = take_slot(b);
                return 1;
            end
            for (b = open_cnt - 1; b > cur_blk; b--)
            begin
                if (free_head[b] < SLOTS)
                begin
                    cur_blk = b;
                    h = take_slot(b);
                    return 1;
                end
            end
            return 0;
        endfunction

        function void release_slot(int b, int s);
            int base;
            int nx;
            int pv;
            base = b * SLOTS;
            nx = used_next[base + s];
            pv = used_prev[base + s];
            if (nx < SLOTS)
                used_prev[base + nx] = pv;
            if (pv < SLOTS)
                used_next[base + pv] = nx;
            else
                used_head[b] = nx;
            used_next[base + s] = NONE;
            used_prev[base + s] = NONE;
            busy[base + s] = 0;
            free_next[base + s] = free_head[b];
            free_head[b] = s;
        endfunction

        function void release_all();
            int s;
            int nx;
            int base;
            for (int b = open_cnt - 1; b >= 0; b--)
            begin
                base = b * SLOTS;
                s = used_head[b];
                for (int g = 0; s < SLOTS && g < SLOTS; g++)
                begin
                    nx = used_next[base + s];
                    free_next[base + s] = free_head[b];
                    free_head[b] = s;
                    used_next[base + s] = NONE;
                    used_prev[base + s] = NONE;
                    busy[base + s] = 0;
                    s = nx;
                end
                used_head[b] = NONE;
            end
        endfunction

        // Note an accepted request and queue the response it causes.
        function void note_request(op_t op, logic [HANDLE_W-1:0] handle);
            answer_t a;
            int h;
            int b;
            int s;
            a.status  = ST_OK;
            a.granted = '0;
            b = handle / SLOTS;
            s = handle % SLOTS;
            case (op)
                OP_ALLOC:
                begin
                    if (allocate(h))
                        a.granted = h[HANDLE_W-1:0];
                    else
                        a.status = ST_FULL;
                end
                OP_FREE_ALL: release_all();
                default:
                begin
                    if (b >= open_cnt)
                        a.status = ST_RANGE;
                    else if (!busy[b * SLOTS + s])
                        a.status = ST_NOT_USED;
                    else if (op == OP_FREE)
                        release_slot(b, s);
                end
            endcase
            pending.push_back(a);
        endfunction

        // Compare one response beat with the oldest expectation.
        function void check_response(logic [STATUS_W-1:0] st, logic [HANDLE_W-1:0] gh);
            answer_t a;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("unexpected response status=%0d handle=%0d", st, gh));
                return;
            end
            a = pending.pop_front();
            if (st !== a.status)
                report_mismatch($sformatf("status %0d, expected %0d", st, a.status));
            if (gh !== a.granted)
                report_mismatch($sformatf("granted_handle %0d, expected %0d", gh, a.granted));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   hold_off;

    fspa_req_if req ();
    fspa_rsp_if rsp ();

    pool_scoreboard pool;

    fixed_slot_pool_allocator i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle counter and overall timeout.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Response side: sample at the rising edge, drive ready at the falling edge.
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            pool.check_response(rsp.status, rsp.granted_handle);
    end

    always @(negedge clk)
    begin
        if (hold_off)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one request beat and wait until it is accepted. Valid is left
    // high; the next request or the drain takes it down.
    task automatic send_request(op_t op, logic [HANDLE_W-1:0] handle);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid     <= 1'b1;
        req.operation <= op;
        req.handle    <= handle;
        do
            @(posedge clk);
        while (!req.ready);
        pool.note_request(op, handle);
        @(negedge clk);
    endtask

    // Pick a handle, mostly one that is live or in an open block.
    function automatic logic [HANDLE_W-1:0] pick_handle();
        int r;
        int lim;
        r = $urandom_range(99);
        lim = (pool.open_cnt > 0) ? pool.open_cnt * SLOTS - 1 : 0;
        if (r < 70 && pool.open_cnt > 0)
            return HANDLE_W'($urandom_range(lim));
        return HANDLE_W'($urandom_range(TOTAL - 1));
    endfunction

    // One random request, with the operation mix given in percent.
    task automatic random_request(int alloc_pct, int free_pct, int all_pct);
        int r;
        r = $urandom_range(99);
        if (r < alloc_pct)
            send_request(OP_ALLOC, HANDLE_W'($urandom));
        else if (r < alloc_pct + free_pct)
            send_request(OP_FREE, pick_handle());
        else if (r < alloc_pct + free_pct + all_pct)
            send_request(OP_FREE_ALL, HANDLE_W'($urandom));
        else
            send_request(OP_QUERY, pick_handle());
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (pool.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    initial
    begin
        pool = new();
        pool.clear();
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off       = 1'b0;
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.operation  = OP_ALLOC;
        req.handle     = '0;
        rsp.ready      = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty pool, extremes of the handle, each operation.
        send_request(OP_QUERY, '0);
        send_request(OP_FREE, '1);
        send_request(OP_FREE_ALL, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_QUERY, '0);
        send_request(OP_QUERY, 10'd1);
        send_request(OP_FREE, 10'd63);
        send_request(OP_QUERY, 10'd64);
        send_request(OP_ALLOC, '1);
        send_request(OP_FREE, '0);
        send_request(OP_FREE, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE_ALL, '1);
        send_request(OP_QUERY, 10'd1);
        send_request(OP_FREE, 10'd1023);

        // Fill the whole pool, then twice more for the full status.
        repeat (TOTAL + 2) send_request(OP_ALLOC, '0);
        send_request(OP_QUERY, 10'd1023);
        // Free slots in a low and a high block, then wrap the search.
        send_request(OP_FREE, 10'd5);
        send_request(OP_FREE, 10'd1000);
        send_request(OP_FREE, 10'd3);
        repeat (4) send_request(OP_ALLOC, '0);
        send_request(OP_FREE_ALL, '0);
        drain();

        // Random phases with different idling.
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1 || ph == 3) ? 68 : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? 68 : 0;
            if (ph == 3)
            begin
                send_idle_pct  = 14;
                recv_stall_pct = 14;
            end
            if (ph == 2)
            begin
                // Receiver holds off while requests keep coming.
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(posedge clk);
                        hold_off = 1'b0;
                    end
                    repeat (20) random_request(40, 30, 2);
                join
            end
            repeat (130) random_request((ph == 0) ? 65 : 45, 30, 2);
            drain();
        end

        if (pool.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

/* filelist.f */
rtl/core/fspa_pkg.sv
rtl/core/fspa_req_if.sv
rtl/core/fspa_rsp_if.sv
rtl/core/fspa_ctrl.sv
rtl/core/fspa_dpath.sv
rtl/core/fixed_slot_pool_allocator.sv
rtl/core/fspa_checker.sv
sim/tb_fixed_slot_pool_allocator.sv
